/* hdl/lfa_pkg.sv */
// lfa_pkg: shared constants, types and tables of the lattice fourier accumulator
// no dependencies; used by every other file of the block
package lfa_pkg;

   localparam int PHASE_BITS   = 16;
   localparam int SAMPLE_BITS  = 32;
   localparam int K_BITS       = 16;
   localparam int R_BITS       = 8;
   localparam int S_BITS       = 32;
   localparam int SAMPLE_USE   = (SAMPLE_BITS < S_BITS) ? SAMPLE_BITS : S_BITS;
   localparam int SUM_BITS     = 48;
   localparam int ACC_EXT_BITS = SUM_BITS + 1;
   localparam int DOT_BITS     = 16;
   localparam int DOT_WIDE     = 24;
   localparam int TURN_BITS    = 32;
   localparam int ANG_BITS     = 34;
   localparam int XY_BITS      = 34;
   localparam int PROD_BITS    = 64;
   localparam int TERM_BITS    = 34;
   localparam int FRAC_SHIFT   = 30;
   localparam int CORDIC_STEPS = 24;
   localparam int ITER_BITS    = $clog2(CORDIC_STEPS);
   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);

   localparam logic signed [XY_BITS-1:0]   CORDIC_X0    = XY_BITS'(652032874);
   localparam logic signed [ANG_BITS-1:0]  QUARTER_TURN = ANG_BITS'(1) << 30;
   localparam logic signed [ANG_BITS-1:0]  HALF_TURN    = ANG_BITS'(1) << 31;
   localparam logic signed [PROD_BITS-1:0] ROUND_HALF   = PROD_BITS'(1) << (FRAC_SHIFT - 1);
   localparam logic signed [SUM_BITS-1:0]  ACC_MAX      = {1'b0, {(SUM_BITS-1){1'b1}}};
   localparam logic signed [SUM_BITS-1:0]  ACC_MIN      = {1'b1, {(SUM_BITS-1){1'b0}}};

   typedef struct packed {
      logic [PHASE_BITS-1:0]    phase;
      logic signed [S_BITS-1:0] sample_re;
      logic signed [S_BITS-1:0] sample_im;
      logic                     first_term;
      logic                     last_term;
   } lfa_item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } lfa_qstat_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_ROTATE,
      BK_MULT,
      BK_ACC
   } lfa_back_state_type;

   // atan(2^-i) in units of 2^-32 turn
   function automatic logic signed [ANG_BITS-1:0] atan_turn(input logic [ITER_BITS-1:0] i);
      logic [TURN_BITS-1:0] v;
      case (i)
         5'd0:    v = 32'h20000000;
         5'd1:    v = 32'h12E4051E;
         5'd2:    v = 32'h09FB385B;
         5'd3:    v = 32'h051111D4;
         5'd4:    v = 32'h028B0D43;
         5'd5:    v = 32'h0145D7E1;
         5'd6:    v = 32'h00A2F61E;
         5'd7:    v = 32'h00517C55;
         5'd8:    v = 32'h0028BE53;
         5'd9:    v = 32'h00145F2F;
         5'd10:   v = 32'h000A2F98;
         5'd11:   v = 32'h000517CC;
         5'd12:   v = 32'h00028BE6;
         5'd13:   v = 32'h000145F3;
         5'd14:   v = 32'h0000A2FA;
         5'd15:   v = 32'h0000517D;
         5'd16:   v = 32'h000028BE;
         5'd17:   v = 32'h0000145F;
         5'd18:   v = 32'h00000A30;
         5'd19:   v = 32'h00000518;
         5'd20:   v = 32'h0000028C;
         5'd21:   v = 32'h00000146;
         5'd22:   v = 32'h000000A3;
         5'd23:   v = 32'h00000051;
         default: v = '0;
      endcase
      return $signed(ANG_BITS'(v));
   endfunction

   // keep the low sample bits, sign-extended
   function automatic logic signed [S_BITS-1:0] sample_take(input logic [S_BITS-1:0] v);
      logic [S_BITS-1:0] t;
      t = v << (S_BITS - SAMPLE_USE);
      return $signed(t) >>> (S_BITS - SAMPLE_USE);
   endfunction

endpackage

/* hdl/lfa_channels.sv */
// lfa_channels: request and response channel interfaces of the accumulator
// depends on lfa_pkg for field widths
interface lfa_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [lfa_pkg::K_BITS-1:0]            k_turn_x;
   logic [lfa_pkg::K_BITS-1:0]            k_turn_y;
   logic [lfa_pkg::K_BITS-1:0]            k_turn_z;
   logic signed [lfa_pkg::R_BITS-1:0]     r_x;
   logic signed [lfa_pkg::R_BITS-1:0]     r_y;
   logic signed [lfa_pkg::R_BITS-1:0]     r_z;
   logic signed [lfa_pkg::S_BITS-1:0]     sample_re;
   logic signed [lfa_pkg::S_BITS-1:0]     sample_im;
   logic                                  first_term;
   logic                                  last_term;

   modport source (output valid, k_turn_x, k_turn_y, k_turn_z, r_x, r_y, r_z,
                   sample_re, sample_im, first_term, last_term, input ready);
   modport sink   (input valid, k_turn_x, k_turn_y, k_turn_z, r_x, r_y, r_z,
                   sample_re, sample_im, first_term, last_term, output ready);
endinterface

interface lfa_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [lfa_pkg::SUM_BITS-1:0]   sum_re;
   logic signed [lfa_pkg::SUM_BITS-1:0]   sum_im;
   logic                                  saturated;

   modport source (output valid, sum_re, sum_im, saturated, input ready);
   modport sink   (input valid, sum_re, sum_im, saturated, output ready);
endinterface

/* hdl/lfa_front.sv */
// lfa_front: takes requests, forms the phase k.r in turns and pushes work to the queue
// depends on lfa_pkg and lfa_channels
module lfa_front (
   input  logic                  clock,
   input  logic                  reset,
   lfa_req_if.sink               req_chan,
   input  lfa_pkg::lfa_qstat_type q_stat,
   output logic                  q_push,
   output lfa_pkg::lfa_item_type q_item
);

   logic                                 valid_ff, valid_in;
   logic [lfa_pkg::DOT_BITS-1:0]         px_ff, px_in;
   logic [lfa_pkg::DOT_BITS-1:0]         py_ff, py_in;
   logic [lfa_pkg::DOT_BITS-1:0]         pz_ff, pz_in;
   logic signed [lfa_pkg::S_BITS-1:0]    sre_ff, sre_in;
   logic signed [lfa_pkg::S_BITS-1:0]    sim_ff, sim_in;
   logic                                 first_ff, first_in;
   logic                                 last_ff, last_in;
   logic                                 take;
   logic [lfa_pkg::DOT_BITS-1:0]         dot;
   logic [lfa_pkg::DOT_WIDE-1:0]         dot_wide;

   assign req_chan.ready = !valid_ff || !q_stat.full;
   assign take           = req_chan.valid && req_chan.ready;
   assign q_push         = valid_ff && !q_stat.full;

   // products mod one turn
   always_comb begin
      px_in    = req_chan.k_turn_x * lfa_pkg::DOT_BITS'(req_chan.r_x);
      py_in    = req_chan.k_turn_y * lfa_pkg::DOT_BITS'(req_chan.r_y);
      pz_in    = req_chan.k_turn_z * lfa_pkg::DOT_BITS'(req_chan.r_z);
      sre_in   = lfa_pkg::sample_take(req_chan.sample_re);
      sim_in   = lfa_pkg::sample_take(req_chan.sample_im);
      first_in = req_chan.first_term;
      last_in  = req_chan.last_term;
      valid_in = take || (valid_ff && !q_push);
   end

   always_comb begin
      dot                = px_ff + py_ff + pz_ff;
      dot_wide           = {dot, {(lfa_pkg::DOT_WIDE-lfa_pkg::DOT_BITS){1'b0}}};
      q_item.phase       = dot_wide[lfa_pkg::DOT_WIDE-1 -: lfa_pkg::PHASE_BITS];
      q_item.sample_re   = sre_ff;
      q_item.sample_im   = sim_ff;
      q_item.first_term  = first_ff;
      q_item.last_term   = last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         px_ff    <= px_in;
         py_ff    <= py_in;
         pz_ff    <= pz_in;
         sre_ff   <= sre_in;
         sim_ff   <= sim_in;
         first_ff <= first_in;
         last_ff  <= last_in;
      end
   end

endmodule

/* hdl/lfa_queue.sv */
// lfa_queue: short first-in first-out queue between front and back
// depends on lfa_pkg
module lfa_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  lfa_pkg::lfa_item_type  push_item,
   input  logic                   pop,
   output lfa_pkg::lfa_item_type  head_item,
   output lfa_pkg::lfa_qstat_type stat
);

   lfa_pkg::lfa_item_type           mem_ff [lfa_pkg::QUEUE_DEPTH];
   logic [lfa_pkg::QPTR_BITS-1:0]   wr_ff, wr_in;
   logic [lfa_pkg::QPTR_BITS-1:0]   rd_ff, rd_in;
   logic [lfa_pkg::QPTR_BITS:0]     count_ff, count_in;

   assign head_item  = mem_ff[rd_ff];
   assign stat.full  = (count_ff == (lfa_pkg::QPTR_BITS+1)'(lfa_pkg::QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);

   always_comb begin
      wr_in    = push ? wr_ff + 1'b1 : wr_ff;
      rd_in    = pop ? rd_ff + 1'b1 : rd_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_item;
      end
   end

endmodule

/* hdl/lfa_back.sv */
// lfa_back: iterative cordic phasor, shared complex multiplier and saturating accumulator
// depends on lfa_pkg and lfa_channels
module lfa_back (
   input  logic                   clock,
   input  logic                   reset,
   input  lfa_pkg::lfa_item_type  q_item,
   input  lfa_pkg::lfa_qstat_type q_stat,
   output logic                   q_pop,
   lfa_rsp_if.source              rsp_chan
);

   localparam logic [2:0] MUL_LAST = 3'd4;

   lfa_pkg::lfa_back_state_type           state_ff, state_in;
   logic [lfa_pkg::ITER_BITS-1:0]         iter_ff, iter_in;
   logic [2:0]                            mcnt_ff, mcnt_in;
   logic signed [lfa_pkg::XY_BITS-1:0]    x_ff, x_in, y_ff, y_in;
   logic signed [lfa_pkg::ANG_BITS-1:0]   z_ff, z_in;
   logic                                  neg_ff, neg_in;
   logic signed [lfa_pkg::S_BITS-1:0]     sre_ff, sre_in, sim_ff, sim_in;
   logic                                  first_ff, first_in, last_ff, last_in;
   logic signed [lfa_pkg::PROD_BITS-1:0]  prod_ff, prod_in;
   logic signed [lfa_pkg::PROD_BITS-1:0]  tre_ff, tre_in, tim_ff, tim_in;
   logic signed [lfa_pkg::SUM_BITS-1:0]   acc_re_ff, acc_re_in, acc_im_ff, acc_im_in;
   logic                                  sat_ff, sat_in;
   logic                                  rsp_valid_ff, rsp_valid_in;
   logic signed [lfa_pkg::SUM_BITS-1:0]   rsp_re_ff, rsp_re_in, rsp_im_ff, rsp_im_in;
   logic                                  rsp_sat_ff, rsp_sat_in;

   logic signed [lfa_pkg::TURN_BITS-1:0]  z_turn;
   logic signed [lfa_pkg::ANG_BITS-1:0]   z_ext;
   logic signed [lfa_pkg::XY_BITS-1:0]    x_sh, y_sh, x_nx, y_nx;
   logic signed [lfa_pkg::ANG_BITS-1:0]   z_nx;
   logic signed [lfa_pkg::S_BITS-1:0]     mult_a, mult_b;
   logic signed [lfa_pkg::PROD_BITS-1:0]  rnd_re, rnd_im, shr_re, shr_im;
   logic signed [lfa_pkg::TERM_BITS-1:0]  term_re, term_im;
   logic signed [lfa_pkg::SUM_BITS-1:0]   base_re, base_im;
   logic signed [lfa_pkg::ACC_EXT_BITS-1:0] ext_re, ext_im;
   logic                                  clip_re, clip_im, out_free;

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.sum_re    = rsp_re_ff;
   assign rsp_chan.sum_im    = rsp_im_ff;
   assign rsp_chan.saturated = rsp_sat_ff;

   // phase as a signed angle in units of 2^-32 turn, folded into the right half plane on load
   always_comb begin
      z_turn = $signed({q_item.phase, {(lfa_pkg::TURN_BITS-lfa_pkg::PHASE_BITS){1'b0}}});
      z_ext  = lfa_pkg::ANG_BITS'(z_turn);
   end

   // one cordic step
   always_comb begin
      x_sh = x_ff >>> iter_ff;
      y_sh = y_ff >>> iter_ff;
      if (!z_ff[lfa_pkg::ANG_BITS-1]) begin
         x_nx = x_ff - y_sh;
         y_nx = y_ff + x_sh;
         z_nx = z_ff - lfa_pkg::atan_turn(iter_ff);
      end else begin
         x_nx = x_ff + y_sh;
         y_nx = y_ff - x_sh;
         z_nx = z_ff + lfa_pkg::atan_turn(iter_ff);
      end
   end

   // shared multiplier: re = s_re*c + s_im*s, im = s_im*c - s_re*s
   always_comb begin
      case (mcnt_ff[1:0])
         2'd0:    begin mult_a = sre_ff; mult_b = x_ff[lfa_pkg::S_BITS-1:0]; end
         2'd1:    begin mult_a = sim_ff; mult_b = y_ff[lfa_pkg::S_BITS-1:0]; end
         2'd2:    begin mult_a = sim_ff; mult_b = x_ff[lfa_pkg::S_BITS-1:0]; end
         default: begin mult_a = sre_ff; mult_b = y_ff[lfa_pkg::S_BITS-1:0]; end
      endcase
      prod_in = mult_a * mult_b;
   end

   // rounding and saturating add
   always_comb begin
      rnd_re  = tre_ff + lfa_pkg::ROUND_HALF;
      rnd_im  = tim_ff + lfa_pkg::ROUND_HALF;
      shr_re  = rnd_re >>> lfa_pkg::FRAC_SHIFT;
      shr_im  = rnd_im >>> lfa_pkg::FRAC_SHIFT;
      term_re = shr_re[lfa_pkg::TERM_BITS-1:0];
      term_im = shr_im[lfa_pkg::TERM_BITS-1:0];
      base_re = first_ff ? '0 : acc_re_ff;
      base_im = first_ff ? '0 : acc_im_ff;
      ext_re  = lfa_pkg::ACC_EXT_BITS'(base_re) + lfa_pkg::ACC_EXT_BITS'(term_re);
      ext_im  = lfa_pkg::ACC_EXT_BITS'(base_im) + lfa_pkg::ACC_EXT_BITS'(term_im);
      clip_re = ext_re[lfa_pkg::ACC_EXT_BITS-1] != ext_re[lfa_pkg::SUM_BITS-1];
      clip_im = ext_im[lfa_pkg::ACC_EXT_BITS-1] != ext_im[lfa_pkg::SUM_BITS-1];
   end

   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      state_in     = state_ff;
      iter_in      = iter_ff;
      mcnt_in      = mcnt_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      z_in         = z_ff;
      neg_in       = neg_ff;
      sre_in       = sre_ff;
      sim_in       = sim_ff;
      first_in     = first_ff;
      last_in      = last_ff;
      tre_in       = tre_ff;
      tim_in       = tim_ff;
      acc_re_in    = acc_re_ff;
      acc_im_in    = acc_im_ff;
      sat_in       = sat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_re_in    = rsp_re_ff;
      rsp_im_in    = rsp_im_ff;
      rsp_sat_in   = rsp_sat_ff;
      q_pop        = 1'b0;
      case (state_ff)
         lfa_pkg::BK_IDLE: begin
            if (!q_stat.empty) begin
               q_pop    = 1'b1;
               sre_in   = q_item.sample_re;
               sim_in   = q_item.sample_im;
               first_in = q_item.first_term;
               last_in  = q_item.last_term;
               x_in     = lfa_pkg::CORDIC_X0;
               y_in     = '0;
               iter_in  = '0;
               if (z_ext > lfa_pkg::QUARTER_TURN) begin
                  z_in   = z_ext - lfa_pkg::HALF_TURN;
                  neg_in = 1'b1;
               end else if (z_ext < -lfa_pkg::QUARTER_TURN) begin
                  z_in   = z_ext + lfa_pkg::HALF_TURN;
                  neg_in = 1'b1;
               end else begin
                  z_in   = z_ext;
                  neg_in = 1'b0;
               end
               state_in = lfa_pkg::BK_ROTATE;
            end
         end
         lfa_pkg::BK_ROTATE: begin
            x_in    = x_nx;
            y_in    = y_nx;
            z_in    = z_nx;
            iter_in = iter_ff + 1'b1;
            if (iter_ff == lfa_pkg::ITER_BITS'(lfa_pkg::CORDIC_STEPS - 1)) begin
               if (neg_ff) begin
                  x_in = -x_nx;
                  y_in = -y_nx;
               end
               mcnt_in  = '0;
               state_in = lfa_pkg::BK_MULT;
            end
         end
         lfa_pkg::BK_MULT: begin
            mcnt_in = mcnt_ff + 1'b1;
            case (mcnt_ff)
               3'd1:    tre_in = prod_ff;
               3'd2:    tre_in = tre_ff + prod_ff;
               3'd3:    tim_in = prod_ff;
               3'd4:    tim_in = tim_ff - prod_ff;
               default: ;
            endcase
            if (mcnt_ff == MUL_LAST) begin
               state_in = lfa_pkg::BK_ACC;
            end
         end
         lfa_pkg::BK_ACC: begin
            if (out_free || !last_ff) begin
               acc_re_in = clip_re ? (ext_re[lfa_pkg::ACC_EXT_BITS-1] ? lfa_pkg::ACC_MIN
                                                                      : lfa_pkg::ACC_MAX)
                                   : ext_re[lfa_pkg::SUM_BITS-1:0];
               acc_im_in = clip_im ? (ext_im[lfa_pkg::ACC_EXT_BITS-1] ? lfa_pkg::ACC_MIN
                                                                      : lfa_pkg::ACC_MAX)
                                   : ext_im[lfa_pkg::SUM_BITS-1:0];
               sat_in    = (sat_ff && !first_ff) || clip_re || clip_im;
               if (last_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_re_in    = acc_re_in;
                  rsp_im_in    = acc_im_in;
                  rsp_sat_in   = sat_in;
               end
               state_in = lfa_pkg::BK_IDLE;
            end
         end
         default: state_in = lfa_pkg::BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lfa_pkg::BK_IDLE;
         rsp_valid_ff <= 1'b0;
         acc_re_ff    <= '0;
         acc_im_ff    <= '0;
         sat_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         acc_re_ff    <= acc_re_in;
         acc_im_ff    <= acc_im_in;
         sat_ff       <= sat_in;
      end
   end

   always_ff @(posedge clock) begin
      iter_ff    <= iter_in;
      mcnt_ff    <= mcnt_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      z_ff       <= z_in;
      neg_ff     <= neg_in;
      sre_ff     <= sre_in;
      sim_ff     <= sim_in;
      first_ff   <= first_in;
      last_ff    <= last_in;
      prod_ff    <= prod_in;
      tre_ff     <= tre_in;
      tim_ff     <= tim_in;
      rsp_re_ff  <= rsp_re_in;
      rsp_im_ff  <= rsp_im_in;
      rsp_sat_ff <= rsp_sat_in;
   end

endmodule

/* hdl/lattice_fourier_accumulator.sv */
// lattice_fourier_accumulator: top level of the lattice fourier sum block
// depends on lfa_pkg, lfa_channels, lfa_front, lfa_queue and lfa_back
//
//   channel    dir   fields                                              handshake
//   req_chan   in    k_turn_x/y/z, r_x/y/z, sample_re/im, first/last     valid/ready
//   rsp_chan   out   sum_re, sum_im, saturated                           valid/ready
//
// in the back end each request is loaded, then takes 24 cordic steps on one
// shared rotation unit, the complex product on the shared 32x32 multiplier and one saturating add
// the front and a four-deep queue keep taking requests while the back end works
// reset clears the accumulators, the saturation flag, the queue, the front valid flag and the response valid flag
// a stalled response holds only the back end on a last request; the queue absorbs the rest
module lattice_fourier_accumulator (
   input  logic       clock,
   input  logic       reset,
   lfa_req_if.sink    req_chan,
   lfa_rsp_if.source  rsp_chan
);

   lfa_pkg::lfa_item_type  push_item;
   lfa_pkg::lfa_item_type  head_item;
   lfa_pkg::lfa_qstat_type q_stat;
   logic                   q_push;
   logic                   q_pop;

   lfa_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_stat   (q_stat),
      .q_push   (q_push),
      .q_item   (push_item)
   );

   lfa_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .pop       (q_pop),
      .head_item (head_item),
      .stat      (q_stat)
   );

   lfa_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_item   (head_item),
      .q_stat   (q_stat),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

   a_queue_flags: assert property (@(posedge clock) disable iff (reset)
      !(q_stat.full && q_stat.empty))
      else $error("queue full and empty together");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_stat.empty)
      else $error("pop from empty queue");

   a_push_notfull: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_stat.full)
      else $error("push into full queue");

   a_reset_rsp: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("response valid after reset");

endmodule
